// ===== design/lwps_pkg.sv =====
// Shared types, constants and helpers for the longest-wait process scheduler.
`default_nettype none
package lwps_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int NUM_CORES   = 4;
  localparam int COUNT_BITS  = 16;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CORE_W     = $clog2(NUM_CORES);
  localparam int CCNT_W     = $clog2(NUM_CORES + 1);
  localparam int NRES_W     = $clog2(MAX_RESULTS + 1);
  localparam int QUANTUM_W  = 16;
  localparam int ACTIVE_W   = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = (COUNT_BITS > QUANTUM_W) ? COUNT_BITS : QUANTUM_W;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(50);
  localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = ACTIVE_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUANTUM      = 1'd0,
    REG_ACTIVE_CORES = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_WAIT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_PREEMPT  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_TERM  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TW_NONE,
    TW_INC,
    TW_CREATE,
    TW_DISPATCH,
    TW_YIELD,
    TW_FAULT,
    TW_SETWAIT
  } tbl_op_t;

  typedef struct packed {
    tbl_op_t           op;
    logic [SLOT_W-1:0] addr;
    logic [CORE_W-1:0] core;
    logic              wflag;
    logic [SLOT_W-1:0] wtgt;
  } tbl_cmd_t;

  typedef struct packed {
    status_t               status;
    logic [COUNT_BITS-1:0] run;
    logic [COUNT_BITS-1:0] stop;
    logic [CORE_W-1:0]     core;
    logic                  eligible;
  } tbl_rd_t;

  typedef struct packed {
    kind_t             kind;
    logic [CORE_W-1:0] core;
    logic [SLOT_W-1:0] slot;
  } res_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (v == '1) ? v : v + COUNT_BITS'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lwps_in_if.sv =====
// Input item channel: valid/ready handshake with the request fields.
`default_nettype none
interface lwps_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [lwps_pkg::SLOT_W-1:0] slot;
  logic [lwps_pkg::CORE_W-1:0] core;
  logic                        report_fault;
  logic                        wait_valid;
  logic [lwps_pkg::SLOT_W-1:0] wait_slot;

  modport source (output valid, mode, slot, core, report_fault, wait_valid, wait_slot,
                  input ready);
  modport sink (input valid, mode, slot, core, report_fault, wait_valid, wait_slot,
                output ready);
endinterface
`default_nettype wire

// ===== design/lwps_out_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`default_nettype none
interface lwps_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [lwps_pkg::CORE_W-1:0] out_core;
  logic [lwps_pkg::SLOT_W-1:0] out_slot;
  logic                        last;

  modport source (output valid, kind, out_core, out_slot, last, input ready);
  modport sink (input valid, kind, out_core, out_slot, last, output ready);
endinterface
`default_nettype wire

// ===== design/lwps_slot_table.sv =====
// Process slot table: per-slot state, one read port, one update command per cycle.
`default_nettype none
module lwps_slot_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lwps_pkg::tbl_cmd_t          cmd,
  input  wire logic [lwps_pkg::SLOT_W-1:0] rd_addr,
  output lwps_pkg::tbl_rd_t                rd
);

  lwps_pkg::status_t                   status     [lwps_pkg::NUM_SLOTS];
  logic [lwps_pkg::COUNT_BITS-1:0]     run_ticks  [lwps_pkg::NUM_SLOTS];
  logic [lwps_pkg::COUNT_BITS-1:0]     stop_ticks [lwps_pkg::NUM_SLOTS];
  logic [lwps_pkg::CORE_W-1:0]         slot_core  [lwps_pkg::NUM_SLOTS];
  logic                                wait_flag  [lwps_pkg::NUM_SLOTS];
  logic [lwps_pkg::SLOT_W-1:0]         wait_tgt   [lwps_pkg::NUM_SLOTS];
  logic [lwps_pkg::NUM_SLOTS-1:0]      alive;

  // a waiter is stalled while its target is ready or running
  always_comb begin
    for (int s = 0; s < lwps_pkg::NUM_SLOTS; s++) begin
      alive[s] = (status[s] == lwps_pkg::ST_READY) || (status[s] == lwps_pkg::ST_RUN);
    end
    rd.status   = status[rd_addr];
    rd.run      = run_ticks[rd_addr];
    rd.stop     = stop_ticks[rd_addr];
    rd.core     = slot_core[rd_addr];
    rd.eligible = (status[rd_addr] == lwps_pkg::ST_READY) &&
                  !(wait_flag[rd_addr] && alive[wait_tgt[rd_addr]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < lwps_pkg::NUM_SLOTS; s++) begin
        status[s]     <= lwps_pkg::ST_EMPTY;
        run_ticks[s]  <= '0;
        stop_ticks[s] <= '0;
        slot_core[s]  <= '0;
        wait_flag[s]  <= 1'b0;
        wait_tgt[s]   <= '0;
      end
    end else begin
      unique case (cmd.op)
        lwps_pkg::TW_INC: begin
          if (status[cmd.addr] == lwps_pkg::ST_RUN) begin
            run_ticks[cmd.addr] <= lwps_pkg::sat_inc(run_ticks[cmd.addr]);
          end else if (status[cmd.addr] == lwps_pkg::ST_READY) begin
            stop_ticks[cmd.addr] <= lwps_pkg::sat_inc(stop_ticks[cmd.addr]);
          end
        end
        lwps_pkg::TW_CREATE: begin
          status[cmd.addr]     <= lwps_pkg::ST_READY;
          run_ticks[cmd.addr]  <= '0;
          stop_ticks[cmd.addr] <= '0;
          slot_core[cmd.addr]  <= '0;
          wait_flag[cmd.addr]  <= 1'b0;
          wait_tgt[cmd.addr]   <= '0;
        end
        lwps_pkg::TW_DISPATCH: begin
          status[cmd.addr]     <= lwps_pkg::ST_RUN;
          slot_core[cmd.addr]  <= cmd.core;
          run_ticks[cmd.addr]  <= '0;
          stop_ticks[cmd.addr] <= '0;
        end
        lwps_pkg::TW_YIELD: begin
          status[cmd.addr]    <= lwps_pkg::ST_READY;
          run_ticks[cmd.addr] <= '0;
        end
        lwps_pkg::TW_FAULT: begin
          status[cmd.addr]     <= lwps_pkg::ST_TERM;
          run_ticks[cmd.addr]  <= '0;
          stop_ticks[cmd.addr] <= '0;
        end
        lwps_pkg::TW_SETWAIT: begin
          wait_flag[cmd.addr] <= cmd.wflag;
          wait_tgt[cmd.addr]  <= cmd.wflag ? cmd.wtgt : '0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/lwps_sequencer.sv =====
// Sequencer: item decode, slot scans with one shared comparator, core owners, result queue.
`default_nettype none
module lwps_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lwps_in_if.sink                             req,
  lwps_out_if.source                          res,
  input  wire logic [lwps_pkg::QUANTUM_W-1:0] quantum_ticks,
  input  wire logic [lwps_pkg::ACTIVE_W-1:0]  active_cores,
  output lwps_pkg::tbl_cmd_t                  tcmd,
  output logic [lwps_pkg::SLOT_W-1:0]         rd_addr,
  input  wire lwps_pkg::tbl_rd_t              rd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_REPORT, S_SETWAIT, S_INC, S_CORE, S_PICK,
    S_PICKED, S_CHECK, S_PRE, S_EMIT, S_FLUSH
  } state_t;

  state_t                            state;
  state_t                            ret;
  logic [lwps_pkg::SLOT_W-1:0]       idx;
  logic [lwps_pkg::CCNT_W-1:0]       c;
  logic                              found;
  logic [lwps_pkg::SLOT_W-1:0]       best;
  logic [lwps_pkg::COUNT_BITS-1:0]   best_stop;
  logic [lwps_pkg::NRES_W-1:0]       n;
  logic                              pend_v;
  lwps_pkg::res_t                    pend;
  lwps_pkg::res_t                    res_new;
  logic                              out_valid;
  lwps_pkg::res_t                    out_res;
  logic                              out_last;
  logic                              owner_valid [lwps_pkg::NUM_CORES];
  logic [lwps_pkg::SLOT_W-1:0]       owner_slot  [lwps_pkg::NUM_CORES];

  logic [lwps_pkg::SLOT_W-1:0]       op_slot;
  logic [lwps_pkg::CORE_W-1:0]       op_core;
  logic                              op_fault;
  logic                              op_wv;
  logic [lwps_pkg::SLOT_W-1:0]       op_ws;

  logic                              idx_last;
  logic                              out_free;
  logic                              out_load;
  logic [7:0]                        lim8;
  logic                              c_done;
  logic [lwps_pkg::CORE_W-1:0]       c_idx;
  logic [lwps_pkg::CMP_W-1:0]        cmp_a;
  logic [lwps_pkg::CMP_W-1:0]        cmp_b;
  logic                              gt;
  logic                              create_bad;
  logic                              rep_ok;
  logic [lwps_pkg::SLOT_W-1:0]       rep_slot;
  logic                              room;

  assign req.ready    = (state == S_IDLE);
  assign res.valid    = out_valid;
  assign res.kind     = out_res.kind;
  assign res.out_core = out_res.core;
  assign res.out_slot = out_res.slot;
  assign res.last     = out_last;

  always_comb begin
    idx_last   = (idx == lwps_pkg::SLOT_W'(lwps_pkg::NUM_SLOTS - 1));
    out_free   = !out_valid || res.ready;
    lim8       = (8'(active_cores) > 8'(lwps_pkg::NUM_CORES)) ?
                 8'(lwps_pkg::NUM_CORES) : 8'(active_cores);
    c_done     = (8'(c) >= lim8);
    c_idx      = c[lwps_pkg::CORE_W-1:0];
    room       = (n < lwps_pkg::NRES_W'(lwps_pkg::MAX_RESULTS));
    out_load   = out_free && (((state == S_EMIT) && room && pend_v) || (state == S_FLUSH));
    // shared comparator: stop time during selection, run time against quantum
    cmp_a      = (state == S_PRE) ? lwps_pkg::CMP_W'(rd.run) : lwps_pkg::CMP_W'(rd.stop);
    cmp_b      = (state == S_PRE) ? lwps_pkg::CMP_W'(quantum_ticks) :
                                    lwps_pkg::CMP_W'(best_stop);
    gt         = (cmp_a > cmp_b);
    create_bad = (rd.status == lwps_pkg::ST_READY) || (rd.status == lwps_pkg::ST_RUN);
    rep_ok     = owner_valid[op_core];
    rep_slot   = owner_slot[op_core];

    rd_addr = ((state == S_CREATE) || (state == S_SETWAIT)) ? op_slot : idx;

    tcmd.op    = lwps_pkg::TW_NONE;
    tcmd.addr  = idx;
    tcmd.core  = c_idx;
    tcmd.wflag = op_wv;
    tcmd.wtgt  = op_ws;
    case (state)
      S_CREATE: begin
        tcmd.addr = op_slot;
        if (!create_bad) tcmd.op = lwps_pkg::TW_CREATE;
      end
      S_REPORT: begin
        tcmd.addr = rep_slot;
        if (rep_ok) tcmd.op = op_fault ? lwps_pkg::TW_FAULT : lwps_pkg::TW_YIELD;
      end
      S_SETWAIT: begin
        tcmd.addr = op_slot;
        tcmd.op   = lwps_pkg::TW_SETWAIT;
      end
      S_INC: tcmd.op = lwps_pkg::TW_INC;
      S_PICKED: begin
        tcmd.addr = best;
        if (found && room) tcmd.op = lwps_pkg::TW_DISPATCH;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      n         <= '0;
      for (int i = 0; i < lwps_pkg::NUM_CORES; i++) begin
        owner_valid[i] <= 1'b0;
        owner_slot[i]  <= '0;
      end
    end else begin
      if (out_valid && res.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_slot  <= req.slot;
            op_core  <= req.core;
            op_fault <= req.report_fault;
            op_wv    <= req.wait_valid;
            op_ws    <= req.wait_slot;
            n        <= '0;
            idx      <= '0;
            unique case (lwps_pkg::mode_t'(req.mode))
              lwps_pkg::MODE_CREATE: state <= S_CREATE;
              lwps_pkg::MODE_REPORT: state <= S_REPORT;
              lwps_pkg::MODE_TICK:   state <= S_INC;
              lwps_pkg::MODE_WAIT:   state <= S_SETWAIT;
              default:               state <= S_IDLE;
            endcase
          end
        end
        S_CREATE: begin
          pend   <= '{create_bad ? lwps_pkg::KIND_ERROR : lwps_pkg::KIND_DONE, '0, op_slot};
          pend_v <= 1'b1;
          state  <= S_FLUSH;
        end
        S_REPORT: begin
          if (rep_ok) begin
            owner_valid[op_core] <= 1'b0;
            owner_slot[op_core]  <= '0;
            pend <= '{lwps_pkg::KIND_DONE, op_core, rep_slot};
          end else begin
            pend <= '{lwps_pkg::KIND_ERROR, op_core, '0};
          end
          pend_v <= 1'b1;
          state  <= S_FLUSH;
        end
        S_SETWAIT: begin
          pend   <= '{lwps_pkg::KIND_DONE, '0, op_slot};
          pend_v <= 1'b1;
          state  <= S_FLUSH;
        end
        S_INC: begin
          idx <= idx + 1'b1;
          if (idx_last) begin
            c     <= '0;
            state <= S_CORE;
          end
        end
        S_CORE: begin
          if (c_done) begin
            idx   <= '0;
            state <= S_CHECK;
          end else if (owner_valid[c_idx]) begin
            c <= c + 1'b1;
          end else begin
            idx   <= '0;
            found <= 1'b0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          // strict compare keeps the lower slot on equal stop times
          if (rd.eligible && (!found || gt)) begin
            found     <= 1'b1;
            best      <= idx;
            best_stop <= rd.stop;
          end
          idx <= idx + 1'b1;
          if (idx_last) state <= S_PICKED;
        end
        S_PICKED: begin
          if (found && room) begin
            owner_valid[c_idx] <= 1'b1;
            owner_slot[c_idx]  <= best;
            res_new <= '{lwps_pkg::KIND_DISPATCH, c_idx, best};
            c       <= c + 1'b1;
            ret     <= S_CORE;
            state   <= S_EMIT;
          end else begin
            idx   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd.eligible) begin
            idx   <= '0;
            state <= S_PRE;
          end else begin
            idx <= idx + 1'b1;
            if (idx_last) state <= S_FLUSH;
          end
        end
        S_PRE: begin
          idx <= idx + 1'b1;
          if ((rd.status == lwps_pkg::ST_RUN) && gt) begin
            res_new <= '{lwps_pkg::KIND_PREEMPT, rd.core, idx};
            ret     <= idx_last ? S_FLUSH : S_PRE;
            state   <= S_EMIT;
          end else if (idx_last) begin
            state <= S_FLUSH;
          end
        end
        S_EMIT: begin
          // one result held back so the final one can carry last
          if (!room) begin
            state <= ret;
          end else if (!pend_v) begin
            pend   <= res_new;
            pend_v <= 1'b1;
            n      <= n + 1'b1;
            state  <= ret;
          end else if (out_free) begin
            out_res   <= pend;
            out_last  <= 1'b0;
            out_valid <= 1'b1;
            pend      <= res_new;
            n         <= n + 1'b1;
            state     <= ret;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_res   <= pend_v ? pend : lwps_pkg::res_t'{lwps_pkg::KIND_DONE, '0, '0};
            out_last  <= 1'b1;
            out_valid <= 1'b1;
            pend_v    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/longest_wait_process_scheduler.sv =====
// Top level: configuration registers, slot table and scheduling sequencer.
// Create, core report, set-wait: the item's state updates the table, then S_FLUSH registers
// the result and returns to S_IDLE for the next item. Tick: a counter sweep over all 16 slots;
// per active core, a skip if busy or else a longest-wait scan and dispatch; a waiter search and,
// if one is left, a quantum scan for preempts, all serial on one slot-read port and comparator.
// Synchronous reset empties all slots, frees all cores, quantum 50, one active core.
`default_nettype none
module longest_wait_process_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lwps_in_if.sink                              req,
  lwps_out_if.source                           res,
  input  wire logic                            cfg_we,
  input  wire logic [lwps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lwps_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [lwps_pkg::QUANTUM_W-1:0] quantum_ticks;
  logic [lwps_pkg::ACTIVE_W-1:0]  active_cores;
  lwps_pkg::tbl_cmd_t             tcmd;
  lwps_pkg::tbl_rd_t              trd;
  logic [lwps_pkg::SLOT_W-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks <= lwps_pkg::QUANTUM_RESET;
      active_cores  <= lwps_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (lwps_pkg::cfg_reg_t'(cfg_index))
        lwps_pkg::REG_QUANTUM:      quantum_ticks <= cfg_data[lwps_pkg::QUANTUM_W-1:0];
        lwps_pkg::REG_ACTIVE_CORES: active_cores  <= cfg_data[lwps_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  lwps_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (tcmd),
    .rd_addr (rd_addr),
    .rd      (trd)
  );

  lwps_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .res           (res),
    .quantum_ticks (quantum_ticks),
    .active_cores  (active_cores),
    .tcmd          (tcmd),
    .rd_addr       (rd_addr),
    .rd            (trd)
  );

endmodule
`default_nettype wire
